// ----- hw/rtl/bcel_pkg.sv -----
// ----------------------------------------------------------------------------
// bcel_pkg
// Shared types, widths and helpers of the bit change event logger.
// ----------------------------------------------------------------------------
`default_nettype none

package bcel_pkg;

  localparam int LOG_DEPTH_DEF        = 16;
  localparam int NUM_RECORDS_DEF      = 16;
  localparam int WORDS_PER_RECORD_DEF = 64;

  localparam int REC_W   = 4;
  localparam int WIDX_W  = 6;
  localparam int WCODE_W = 2;
  localparam int WORD_W  = 32;
  localparam int FLAG_W  = 11;
  localparam int FILL_W  = 5;
  localparam int BIT_W   = 5;

  // operation codes on the input tuser
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_UNDO   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // width codes
  localparam logic [WCODE_W-1:0] WCODE_8  = 2'd0;
  localparam logic [WCODE_W-1:0] WCODE_16 = 2'd1;
  localparam logic [WCODE_W-1:0] WCODE_32 = 2'd2;

  // result kinds
  localparam logic KIND_CHANGE = 1'b0;
  localparam logic KIND_UNDO   = 1'b1;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_UNDO,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [REC_W-1:0]    rec;
    logic [WIDX_W-1:0]   widx;
    logic [WCODE_W-1:0]  wcode;
    logic [WORD_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [REC_W-1:0]   rec;
    logic [FLAG_W-1:0]  flag;
    logic               val;
    logic [WCODE_W-1:0] wcode;
  } log_entry_t;

  localparam int LOG_ENTRY_W = $bits(log_entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_S_READ,
    ST_S_SCAN,
    ST_U_READ,
    ST_U_WRITE
  } back_state_t;

  function automatic logic [WORD_W-1:0] word_mask(input logic [WCODE_W-1:0] wcode);
    logic [WORD_W-1:0] m;
    m = '1;
    unique case (wcode)
      WCODE_8:  m = 32'h0000_00FF;
      WCODE_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // log2 of the word width, code 3 treated as 32 bits
  function automatic logic [2:0] width_shift(input logic [WCODE_W-1:0] wcode);
    logic [2:0] s;
    s = 3'd5;
    unique case (wcode)
      WCODE_8:  s = 3'd3;
      WCODE_16: s = 3'd4;
      default:  s = 3'd5;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bcel_ram.sv -----
// ----------------------------------------------------------------------------
// bcel_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bcel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bcel_front.sv -----
// ----------------------------------------------------------------------------
// bcel_front
// Accepts input beats, drops ignored ones and queues commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bcel_front #(
  parameter int NUM_RECORDS      = bcel_pkg::NUM_RECORDS_DEF,
  parameter int WORDS_PER_RECORD = bcel_pkg::WORDS_PER_RECORD_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [47:0]   s_tdata,
  input  wire logic [1:0]    s_tuser,
  input  wire logic          clearing,
  output logic               q_valid,
  input  wire logic          q_ready,
  output bcel_pkg::cmd_t     q_cmd
);

  bcel_pkg::cmd_t               fifo [2];
  logic                         wptr;
  logic                         rptr;
  logic [1:0]                   fill;
  logic [bcel_pkg::REC_W-1:0]   rec;
  logic [bcel_pkg::WIDX_W-1:0]  widx;
  logic [bcel_pkg::WCODE_W-1:0] wcode;
  logic [bcel_pkg::WORD_W-1:0]  value;
  logic                         keep;
  bcel_pkg::cmd_t               cmd;
  logic                         push;
  logic                         pop;

  assign rec   = s_tdata[3:0];
  assign widx  = s_tdata[9:4];
  assign wcode = s_tdata[11:10];
  assign value = s_tdata[43:12];

  assign s_tready = (fill != 2'd2) && !clearing;

  always_comb begin
    keep       = 1'b0;
    cmd.kind   = bcel_pkg::CMD_SAMPLE;
    cmd.rec    = rec;
    cmd.widx   = widx;
    cmd.wcode  = wcode;
    cmd.value  = value & bcel_pkg::word_mask(wcode);
    unique case (s_tuser)
      bcel_pkg::OP_SAMPLE: begin
        keep = (wcode != 2'd3) && (int'(rec) < NUM_RECORDS)
               && (int'(widx) < WORDS_PER_RECORD);
      end
      bcel_pkg::OP_UNDO: begin
        keep     = 1'b1;
        cmd.kind = bcel_pkg::CMD_UNDO;
      end
      bcel_pkg::OP_CLEAR: begin
        keep     = 1'b1;
        cmd.kind = bcel_pkg::CMD_CLEAR;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push    = s_tvalid && s_tready && keep;
  assign q_valid = (fill != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_cmd   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= cmd;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bcel_back.sv -----
// ----------------------------------------------------------------------------
// bcel_back
// Carries out queued commands: shadow compare, event scan, log and undo.
// ----------------------------------------------------------------------------
`default_nettype none

module bcel_back #(
  parameter int LOG_DEPTH        = bcel_pkg::LOG_DEPTH_DEF,
  parameter int NUM_RECORDS      = bcel_pkg::NUM_RECORDS_DEF,
  parameter int WORDS_PER_RECORD = bcel_pkg::WORDS_PER_RECORD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire bcel_pkg::cmd_t q_cmd,
  output logic             clearing,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,
  output logic [0:0]       m_tuser,
  output logic             m_tlast
);

  localparam int NWORDS = NUM_RECORDS * WORDS_PER_RECORD;
  localparam int ADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CLR_W  = $clog2(NWORDS + 1);
  localparam int LOG_AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  bcel_pkg::back_state_t state, state_next;

  bcel_pkg::cmd_t               cmd;
  logic [ADDR_W-1:0]            addr;
  logic [bcel_pkg::WORD_W-1:0]  diff;
  logic [CLR_W-1:0]             clr_cnt;
  logic [LOG_AW-1:0]            head;
  logic [CNT_W-1:0]             count;
  logic [ADDR_W-1:0]            u_addr;
  logic [bcel_pkg::BIT_W-1:0]   u_bit;
  logic                         u_ok;
  bcel_pkg::log_entry_t         u_ent;

  logic                         out_valid;
  logic                         out_kind;
  logic [bcel_pkg::REC_W-1:0]   out_rec;
  logic [bcel_pkg::FLAG_W-1:0]  out_flag;
  logic                         out_bit;
  logic [bcel_pkg::FILL_W-1:0]  out_fill;
  logic                         out_last;
  logic                         out_free;

  // memory ports
  logic                         sh_we, sh_re;
  logic [ADDR_W-1:0]            sh_waddr, sh_raddr;
  logic [bcel_pkg::WORD_W-1:0]  sh_wdata, sh_rdata;
  logic                         lg_we, lg_re;
  logic [LOG_AW-1:0]            lg_waddr, lg_raddr;
  bcel_pkg::log_entry_t         lg_wdata, lg_rdata;

  // datapath helpers
  logic [ADDR_W-1:0]            q_addr;
  logic [bcel_pkg::WORD_W-1:0]  new_diff;
  logic [bcel_pkg::BIT_W-1:0]   low_idx;
  logic [bcel_pkg::WORD_W-1:0]  diff_after;
  logic [bcel_pkg::FLAG_W-1:0]  scan_flag;
  logic                         log_full;
  logic [SUM_W-1:0]             push_sum;
  logic [SUM_W-1:0]             push_wrap;
  logic [SUM_W-1:0]             head_sum;
  logic [SUM_W-1:0]             head_wrap;
  logic [SUM_W-1:0]             pop_sum;
  logic [SUM_W-1:0]             pop_wrap;
  logic [2:0]                   e_shift;
  logic [bcel_pkg::FLAG_W-1:0]  e_widx;
  logic [bcel_pkg::FLAG_W-1:0]  e_bits;

  // control from the sequencer
  logic                         do_take;
  logic                         do_push;
  logic                         do_pop;
  logic                         do_clear_log;
  logic                         do_emit;
  logic                         do_undo_latch;
  logic                         emit_kind;
  logic [bcel_pkg::REC_W-1:0]   emit_rec;
  logic [bcel_pkg::FLAG_W-1:0]  emit_flag;
  logic                         emit_bit;
  logic                         emit_last;
  logic [CNT_W-1:0]             count_next;
  logic [LOG_AW-1:0]            head_next;

  bcel_ram #(.WIDTH(bcel_pkg::WORD_W), .DEPTH(NWORDS)) u_shadow (
    .clk   (clk),
    .we    (sh_we),
    .waddr (sh_waddr),
    .wdata (sh_wdata),
    .re    (sh_re),
    .raddr (sh_raddr),
    .rdata (sh_rdata)
  );

  bcel_ram #(.WIDTH(bcel_pkg::LOG_ENTRY_W), .DEPTH(LOG_DEPTH)) u_log (
    .clk   (clk),
    .we    (lg_we),
    .waddr (lg_waddr),
    .wdata (lg_wdata),
    .re    (lg_re),
    .raddr (lg_raddr),
    .rdata (lg_rdata)
  );

  assign out_free = !out_valid || m_tready;
  assign clearing = (state == bcel_pkg::ST_CLEAR);

  assign q_addr = ADDR_W'(int'(q_cmd.rec) * WORDS_PER_RECORD + int'(q_cmd.widx));
  // shadow may hold wider bits from an earlier sample of another width
  assign new_diff = (cmd.value ^ sh_rdata) & bcel_pkg::word_mask(cmd.wcode);

  // lowest set bit of the remaining difference
  always_comb begin
    low_idx = '0;
    for (int i = bcel_pkg::WORD_W - 1; i >= 0; i--) begin
      if (diff[i]) begin
        low_idx = bcel_pkg::BIT_W'(i);
      end
    end
  end

  assign diff_after = diff & ~(bcel_pkg::WORD_W'(1) << low_idx);
  assign scan_flag  = (bcel_pkg::FLAG_W'(cmd.widx) << bcel_pkg::width_shift(cmd.wcode))
                      + bcel_pkg::FLAG_W'(low_idx);

  // log slot arithmetic, sums stay below twice the depth
  assign log_full  = (count == CNT_W'(LOG_DEPTH));
  assign push_sum  = SUM_W'(head) + SUM_W'(count);
  assign push_wrap = (push_sum >= SUM_W'(LOG_DEPTH)) ? push_sum - SUM_W'(LOG_DEPTH) : push_sum;
  assign head_sum  = SUM_W'(head) + SUM_W'(1);
  assign head_wrap = (head_sum >= SUM_W'(LOG_DEPTH)) ? head_sum - SUM_W'(LOG_DEPTH) : head_sum;
  assign pop_sum   = push_sum - SUM_W'(1);
  assign pop_wrap  = (pop_sum >= SUM_W'(LOG_DEPTH)) ? pop_sum - SUM_W'(LOG_DEPTH) : pop_sum;

  // undo target decode from the popped entry
  assign e_shift = bcel_pkg::width_shift(lg_rdata.wcode);
  assign e_widx  = lg_rdata.flag >> e_shift;
  assign e_bits  = lg_rdata.flag & ((bcel_pkg::FLAG_W'(1) << e_shift) - bcel_pkg::FLAG_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bcel_pkg::ST_CLEAR: begin
        if (clr_cnt == CLR_W'(NWORDS - 1)) begin
          state_next = bcel_pkg::ST_IDLE;
        end
      end
      bcel_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            bcel_pkg::CMD_SAMPLE: state_next = bcel_pkg::ST_S_READ;
            bcel_pkg::CMD_UNDO: begin
              if (count != '0) begin
                state_next = bcel_pkg::ST_U_READ;
              end
            end
            default: state_next = bcel_pkg::ST_IDLE;
          endcase
        end
      end
      bcel_pkg::ST_S_READ: begin
        state_next = (new_diff != '0) ? bcel_pkg::ST_S_SCAN : bcel_pkg::ST_IDLE;
      end
      bcel_pkg::ST_S_SCAN: begin
        if (out_free && diff_after == '0) begin
          state_next = bcel_pkg::ST_IDLE;
        end
      end
      bcel_pkg::ST_U_READ: state_next = bcel_pkg::ST_U_WRITE;
      bcel_pkg::ST_U_WRITE: begin
        if (out_free) begin
          state_next = bcel_pkg::ST_IDLE;
        end
      end
      default: state_next = bcel_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_ready       = 1'b0;
    sh_we         = 1'b0;
    sh_waddr      = addr;
    sh_wdata      = cmd.value;
    sh_re         = 1'b0;
    sh_raddr      = q_addr;
    lg_we         = 1'b0;
    lg_waddr      = LOG_AW'(push_wrap);
    lg_wdata      = '{rec: cmd.rec, flag: scan_flag, val: cmd.value[low_idx],
                      wcode: cmd.wcode};
    lg_re         = 1'b0;
    lg_raddr      = LOG_AW'(pop_wrap);
    do_take       = 1'b0;
    do_push       = 1'b0;
    do_pop        = 1'b0;
    do_clear_log  = 1'b0;
    do_emit       = 1'b0;
    do_undo_latch = 1'b0;
    emit_kind     = bcel_pkg::KIND_CHANGE;
    emit_rec      = cmd.rec;
    emit_flag     = scan_flag;
    emit_bit      = cmd.value[low_idx];
    emit_last     = (diff_after == '0);
    unique case (state)
      bcel_pkg::ST_CLEAR: begin
        sh_we    = 1'b1;
        sh_waddr = ADDR_W'(clr_cnt);
        sh_wdata = '0;
      end
      bcel_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          do_take = 1'b1;
          unique case (q_cmd.kind)
            bcel_pkg::CMD_SAMPLE: sh_re = 1'b1;
            bcel_pkg::CMD_UNDO: begin
              if (count != '0) begin
                lg_re  = 1'b1;
                do_pop = 1'b1;
              end
            end
            default: do_clear_log = 1'b1;
          endcase
        end
      end
      bcel_pkg::ST_S_READ: begin
        sh_we = 1'b1;
      end
      bcel_pkg::ST_S_SCAN: begin
        if (out_free) begin
          lg_we   = 1'b1;
          if (log_full) begin
            lg_waddr = head;
          end
          do_push = 1'b1;
          do_emit = 1'b1;
        end
      end
      bcel_pkg::ST_U_READ: begin
        sh_re         = 1'b1;
        sh_raddr      = ADDR_W'(int'(lg_rdata.rec) * WORDS_PER_RECORD + int'(e_widx));
        do_undo_latch = 1'b1;
      end
      bcel_pkg::ST_U_WRITE: begin
        emit_kind = bcel_pkg::KIND_UNDO;
        emit_rec  = u_ent.rec;
        emit_flag = u_ent.flag;
        emit_bit  = ~u_ent.val;
        emit_last = 1'b1;
        if (out_free) begin
          do_emit  = 1'b1;
          sh_we    = u_ok;
          sh_waddr = u_addr;
          sh_wdata = u_ent.val ? (sh_rdata & ~(bcel_pkg::WORD_W'(1) << u_bit))
                               : (sh_rdata | (bcel_pkg::WORD_W'(1) << u_bit));
        end
      end
      default: q_ready = 1'b0;
    endcase
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    if (do_clear_log) begin
      head_next  = '0;
      count_next = '0;
    end else if (do_pop) begin
      count_next = count - CNT_W'(1);
    end else if (do_push) begin
      if (log_full) begin
        head_next = LOG_AW'(head_wrap);
      end else begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_take) begin
      cmd  <= q_cmd;
      addr <= q_addr;
    end
    if (state == bcel_pkg::ST_S_READ) begin
      diff <= new_diff;
    end else if (do_push) begin
      diff <= diff_after;
    end
    if (do_undo_latch) begin
      u_ent  <= lg_rdata;
      u_bit  <= bcel_pkg::BIT_W'(e_bits);
      u_addr <= ADDR_W'(int'(lg_rdata.rec) * WORDS_PER_RECORD + int'(e_widx));
      u_ok   <= (int'(lg_rdata.rec) < NUM_RECORDS) && (int'(e_widx) < WORDS_PER_RECORD);
    end
    if (do_emit) begin
      out_kind <= emit_kind;
      out_rec  <= emit_rec;
      out_flag <= emit_flag;
      out_bit  <= emit_bit;
      out_fill <= bcel_pkg::FILL_W'(count_next);
      out_last <= emit_last;
    end
    if (rst) begin
      state     <= bcel_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (state == bcel_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (do_emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_fill, out_bit, out_flag, out_rec};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

// ----- hw/rtl/bit_change_event_logger_core.sv -----
// ----------------------------------------------------------------------------
// bit_change_event_logger_core
// Watches flag words against a shadow copy and reports every changed bit.
// ----------------------------------------------------------------------------
// The slave stream carries one command per beat: sample a word, undo the
// newest logged change or clear the log (operation on s_tuser). The master
// stream carries one result per beat: a change event or an undo write-back
// (kind on m_tuser), with m_tlast on the final result of a command.
// In the back end a sample is a shadow read, then a compare, then one
// change event per changed bit; one event leaves per cycle while the sink
// takes it. An undo is a log read, a shadow read, then a shadow write.
// Ignored commands are dropped in the front and never reach the back end;
// log clears are taken in the idle state. A two-beat command queue sits
// between front and back ends, so input beats are taken while results wait.
// After reset the shadow memory is swept to zero, one word a cycle, over all
// NUM_RECORDS * WORDS_PER_RECORD words; s_tready stays low during the sweep.
// When the sink stalls, the result register holds and the back end waits;
// the front keeps taking beats until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_change_event_logger_core #(
  parameter int LOG_DEPTH        = bcel_pkg::LOG_DEPTH_DEF,
  parameter int NUM_RECORDS      = bcel_pkg::NUM_RECORDS_DEF,
  parameter int WORDS_PER_RECORD = bcel_pkg::WORDS_PER_RECORD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // record, word_index, width_code, word_value
  input  wire logic [1:0]  s_tuser,  // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // event_record, flag_number, bit_value, log_fill
  output logic [0:0]       m_tuser,  // kind
  output logic             m_tlast
);

  logic           q_valid;
  logic           q_ready;
  bcel_pkg::cmd_t q_cmd;
  logic           clearing;

  bcel_front #(
    .NUM_RECORDS      (NUM_RECORDS),
    .WORDS_PER_RECORD (WORDS_PER_RECORD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  bcel_back #(
    .LOG_DEPTH        (LOG_DEPTH),
    .NUM_RECORDS      (NUM_RECORDS),
    .WORDS_PER_RECORD (WORDS_PER_RECORD)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_undo_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("undo write-back without last");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (int'(m_tdata[20:16]) <= LOG_DEPTH))
    else $error("log fill above depth");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input taken during shadow sweep");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the bit change event logger core.
// ----------------------------------------------------------------------------
// Commands go in on the slave stream with random gaps. A behavioral copy of
// the shadow words and the event log predicts every change event and undo
// write-back. Results are taken from the master stream under random
// backpressure and compared field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcel_pkg::*;

  typedef struct {
    logic              kind;
    logic [REC_W-1:0]  rec;
    logic [FLAG_W-1:0] flag;
    logic              bitv;
    logic [FILL_W-1:0] fill;
    logic              last;
  } flag_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // record, word_index, width_code, word_value
  logic [1:0]  s_tuser = '0;  // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // event_record, flag_number, bit_value, log_fill
  logic [0:0]  m_tuser;       // kind
  logic        m_tlast;

  // predictor state
  logic [WORD_W-1:0]  shadow [NUM_RECORDS_DEF*WORDS_PER_RECORD_DEF];
  logic [REC_W-1:0]   lg_rec  [LOG_DEPTH_DEF];
  logic [FLAG_W-1:0]  lg_flag [LOG_DEPTH_DEF];
  logic               lg_val  [LOG_DEPTH_DEF];
  logic [WCODE_W-1:0] lg_wc   [LOG_DEPTH_DEF];
  int unsigned lg_head;
  int unsigned lg_count;

  flag_event_t pending_events[$];
  int errors = 0;
  bit no_idle = 1'b0;

  bit_change_event_logger_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 20);
    end
  end

  // result checker
  always @(posedge clk) begin
    flag_event_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result tdata=%h kind=%b last=%b",
                 $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        e = pending_events.pop_front();
        if (m_tuser[0] !== e.kind) begin
          $display("%0t: kind exp %b got %b", $time, e.kind, m_tuser[0]);
          errors++;
        end
        if (m_tdata[3:0] !== e.rec) begin
          $display("%0t: record exp %0d got %0d", $time, e.rec, m_tdata[3:0]);
          errors++;
        end
        if (m_tdata[14:4] !== e.flag) begin
          $display("%0t: flag exp %0d got %0d", $time, e.flag, m_tdata[14:4]);
          errors++;
        end
        if (m_tdata[15] !== e.bitv) begin
          $display("%0t: bit exp %b got %b", $time, e.bitv, m_tdata[15]);
          errors++;
        end
        if (m_tdata[20:16] !== e.fill) begin
          $display("%0t: fill exp %0d got %0d", $time, e.fill, m_tdata[20:16]);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $display("%0t: last exp %b got %b", $time, e.last, m_tlast);
          errors++;
        end
      end
    end
  end

  function automatic void log_push(logic [REC_W-1:0] rec, logic [FLAG_W-1:0] flag,
                                   logic v, logic [WCODE_W-1:0] wc);
    int unsigned slot;
    if (lg_count >= LOG_DEPTH_DEF) begin
      lg_head = (lg_head + 1) % LOG_DEPTH_DEF;
    end else begin
      lg_count++;
    end
    slot = (lg_head + lg_count - 1) % LOG_DEPTH_DEF;
    lg_rec[slot] = rec;
    lg_flag[slot] = flag;
    lg_val[slot] = v;
    lg_wc[slot] = wc;
  endfunction

  // expected events for one accepted command
  function automatic void predict_events(logic [1:0] op, logic [REC_W-1:0] rec,
                                         logic [WIDX_W-1:0] widx,
                                         logic [WCODE_W-1:0] wc,
                                         logic [WORD_W-1:0] val);
    flag_event_t e;
    int unsigned addr, slot, sh, nbits, bitpos, wi;
    logic [WORD_W-1:0] msk, diff;
    int first_idx;
    first_idx = pending_events.size();
    if (op == OP_SAMPLE) begin
      if (wc > WCODE_32) return;
      sh = 3 + wc;
      nbits = 1 << sh;
      msk = (nbits == 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 1);
      val &= msk;
      addr = rec * WORDS_PER_RECORD_DEF + widx;
      diff = (val ^ shadow[addr]) & msk;
      for (int b = 0; b < nbits; b++) begin
        if (diff[b]) begin
          e.kind = KIND_CHANGE;
          e.rec = rec;
          e.flag = FLAG_W'((int'(widx) << sh) + b);
          e.bitv = val[b];
          log_push(rec, e.flag, val[b], wc);
          e.fill = FILL_W'(lg_count);
          e.last = 1'b0;
          pending_events.push_back(e);
        end
      end
      shadow[addr] = val;
      if (pending_events.size() > first_idx)
        pending_events[pending_events.size()-1].last = 1'b1;
    end else if (op == OP_UNDO) begin
      if (lg_count == 0) return;
      slot = (lg_head + lg_count - 1) % LOG_DEPTH_DEF;
      lg_count--;
      sh = 3 + ((lg_wc[slot] > WCODE_32) ? 2 : lg_wc[slot]);
      wi = lg_flag[slot] >> sh;
      bitpos = lg_flag[slot] & ((1 << sh) - 1);
      e.kind = KIND_UNDO;
      e.rec = lg_rec[slot];
      e.flag = lg_flag[slot];
      e.bitv = ~lg_val[slot];
      e.fill = FILL_W'(lg_count);
      e.last = 1'b1;
      if (wi < WORDS_PER_RECORD_DEF) begin
        addr = lg_rec[slot] * WORDS_PER_RECORD_DEF + wi;
        shadow[addr][bitpos] = e.bitv;
      end
      pending_events.push_back(e);
    end else if (op == OP_CLEAR) begin
      lg_count = 0;
      lg_head = 0;
    end
  endfunction

  task automatic send_cmd(logic [1:0] op, logic [REC_W-1:0] rec, logic [WIDX_W-1:0] widx,
                          logic [WCODE_W-1:0] wc, logic [WORD_W-1:0] val);
    if (!no_idle) begin
      while ($urandom_range(99) < 20) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'd0, val, wc, widx, rec};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_events(op, rec, widx, wc, val);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    wait (pending_events.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    send_cmd(OP_SAMPLE, 0, 0, WCODE_8, 32'hFFFF_FFFF);   // upper bits ignored
    send_cmd(OP_SAMPLE, 0, 0, WCODE_8, 32'h0000_00FF);   // unchanged word
    send_cmd(OP_SAMPLE, 0, 0, 2'd3, 32'h1234_5678);      // bad width code
    send_cmd(2'd3, 1, 1, WCODE_8, 32'hFF);               // unknown operation
    send_cmd(OP_UNDO, 0, 0, WCODE_8, 0);
    send_cmd(OP_UNDO, 0, 0, WCODE_8, 0);
    send_cmd(OP_CLEAR, 0, 0, WCODE_8, 0);
    send_cmd(OP_UNDO, 0, 0, WCODE_8, 0);                 // undo on empty log
    send_cmd(OP_SAMPLE, 15, 63, WCODE_32, 32'hFFFF_FFFF); // log overflows
    send_cmd(OP_UNDO, 0, 0, WCODE_8, 0);
    send_cmd(OP_UNDO, 0, 0, WCODE_8, 0);
    send_cmd(OP_SAMPLE, 15, 63, WCODE_32, 32'h0000_0000);
    send_cmd(OP_SAMPLE, 7, 63, WCODE_16, 32'hAAAA_5555);
    send_cmd(OP_SAMPLE, 7, 63, WCODE_16, 32'h5555_AAAA);
    send_cmd(OP_UNDO, 0, 0, WCODE_8, 0);
    send_cmd(OP_SAMPLE, 8, 21, WCODE_32, 32'h8000_0001);
    send_cmd(OP_UNDO, 0, 0, WCODE_8, 0);
    send_cmd(OP_UNDO, 0, 0, WCODE_8, 0);
    send_cmd(OP_CLEAR, 0, 0, WCODE_8, 0);
    send_cmd(OP_SAMPLE, 8, 21, WCODE_32, 32'h0000_0000);
    drain_results();
  endtask

  task automatic test_random(int n_cmds);
    int unsigned pick, addr;
    logic [REC_W-1:0] rec;
    logic [WIDX_W-1:0] widx;
    logic [WCODE_W-1:0] wc;
    logic [WORD_W-1:0] val;
    for (int i = 0; i < n_cmds; i++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        rec = $urandom_range(3);
        widx = $urandom_range(7);
      end else begin
        rec = $urandom;
        widx = $urandom;
      end
      wc = $urandom_range(2);
      addr = rec * WORDS_PER_RECORD_DEF + widx;
      if (pick < 40) begin
        // flip a few bits of the tracked word
        val = shadow[addr] ^ (32'd1 << $urandom_range(31)) ^ (32'd1 << $urandom_range(31));
        send_cmd(OP_SAMPLE, rec, widx, wc, val);
      end else if (pick < 65) begin
        send_cmd(OP_SAMPLE, rec, widx, wc, $urandom);
      end else if (pick < 85) begin
        send_cmd(OP_UNDO, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 90) begin
        send_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 95) begin
        send_cmd(OP_SAMPLE, rec, widx, 2'd3, $urandom);
      end else begin
        send_cmd(2'd3, rec, widx, wc, $urandom);
      end
    end
  endtask

  task automatic test_pause_until_empty();
    test_random(30);
    drain_results();
    test_random(30);
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    test_random(50);
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (shadow[i]) shadow[i] = '0;
    lg_head = 0;
    lg_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(60);
    test_pause_until_empty();
    test_no_idle();
    test_random(40);
    drain_results();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/bcel_pkg.sv
hw/rtl/bcel_ram.sv
hw/rtl/bcel_front.sv
hw/rtl/bcel_back.sv
hw/rtl/bit_change_event_logger_core.sv
tb/sv/tb_top.sv
